[hw/rtl/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants, types and the microprogram of the trial division
// primality tester.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int STEP_W     = 4;
  localparam int PROG_LEN   = 11;

  typedef logic [3:0]        op_t;
  typedef logic [2:0]        cond_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam op_t OP_NOP      = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;
  localparam op_t OP_SQUARE   = 4'd2;
  localparam op_t OP_DIV_INIT = 4'd3;
  localparam op_t OP_DIV_STEP = 4'd4;
  localparam op_t OP_INC      = 4'd5;
  localparam op_t OP_SET_PASS = 4'd6;
  localparam op_t OP_SET_FAIL = 4'd7;
  localparam op_t OP_EMIT     = 4'd8;

  localparam cond_t COND_NONE     = 3'd0;
  localparam cond_t COND_ALWAYS   = 3'd1;
  localparam cond_t COND_START    = 3'd2;
  localparam cond_t COND_SMALL    = 3'd3;
  localparam cond_t COND_SQ_GT    = 3'd4;
  localparam cond_t COND_DIV_LAST = 3'd5;
  localparam cond_t COND_REM_ZERO = 3'd6;
  localparam cond_t COND_OUT_FREE = 3'd7;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_CHECK    = 4'd1;
  localparam step_t STEP_SQUARE   = 4'd2;
  localparam step_t STEP_CMP_SQ   = 4'd3;
  localparam step_t STEP_DIV_INIT = 4'd4;
  localparam step_t STEP_DIV_STEP = 4'd5;
  localparam step_t STEP_REM_CHK  = 4'd6;
  localparam step_t STEP_INC      = 4'd7;
  localparam step_t STEP_PASS     = 4'd8;
  localparam step_t STEP_FAIL     = 4'd9;
  localparam step_t STEP_EMIT     = 4'd10;

  // When the condition holds the sequencer jumps to target; otherwise it
  // stays on the step if hold is set and advances by one if not.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  hold;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic trivial;
    logic sq_gt;
    logic div_last;
    logic rem_zero;
    logic out_free;
  } status_t;

  function automatic ctrl_t ptd_ucode(input step_t step);
    ctrl_t cw;
    unique case (step)
      STEP_IDLE:     cw = '{OP_LOAD,     COND_START,    STEP_CHECK,    1'b1};
      STEP_CHECK:    cw = '{OP_NOP,      COND_SMALL,    STEP_FAIL,     1'b0};
      STEP_SQUARE:   cw = '{OP_SQUARE,   COND_NONE,     STEP_IDLE,     1'b0};
      STEP_CMP_SQ:   cw = '{OP_NOP,      COND_SQ_GT,    STEP_PASS,     1'b0};
      STEP_DIV_INIT: cw = '{OP_DIV_INIT, COND_NONE,     STEP_IDLE,     1'b0};
      STEP_DIV_STEP: cw = '{OP_DIV_STEP, COND_DIV_LAST, STEP_REM_CHK,  1'b1};
      STEP_REM_CHK:  cw = '{OP_NOP,      COND_REM_ZERO, STEP_FAIL,     1'b0};
      STEP_INC:      cw = '{OP_INC,      COND_ALWAYS,   STEP_SQUARE,   1'b0};
      STEP_PASS:     cw = '{OP_SET_PASS, COND_ALWAYS,   STEP_EMIT,     1'b0};
      STEP_FAIL:     cw = '{OP_SET_FAIL, COND_NONE,     STEP_IDLE,     1'b0};
      STEP_EMIT:     cw = '{OP_EMIT,     COND_OUT_FREE, STEP_IDLE,     1'b1};
      default:       cw = '{OP_NOP,      COND_ALWAYS,   STEP_IDLE,     1'b0};
    endcase
    return cw;
  endfunction

endpackage

[hw/rtl/ptd_sequencer.sv]
// ----------------------------------------------------------------------------
// ptd_sequencer
// Step counter and microprogram table; evaluates the branch condition of
// each control word against the datapath status.
// ----------------------------------------------------------------------------
module ptd_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  ptd_pkg::status_t status,
  output ptd_pkg::ctrl_t   ctrl
);
  import ptd_pkg::*;

  step_t step;
  step_t step_next;
  logic  cond_true;

  always_comb begin
    ctrl = ptd_ucode(step);
    unique case (ctrl.cond)
      COND_NONE:     cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_START:    cond_true = status.start;
      COND_SMALL:    cond_true = status.trivial;
      COND_SQ_GT:    cond_true = status.sq_gt;
      COND_DIV_LAST: cond_true = status.div_last;
      COND_REM_ZERO: cond_true = status.rem_zero;
      COND_OUT_FREE: cond_true = status.out_free;
      default:       cond_true = 1'b0;
    endcase
    priority if (cond_true) begin
      step_next = ctrl.target;
    end else if (ctrl.hold) begin
      step_next = step;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step < step_t'(PROG_LEN))
    else $error("step counter left the program");
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_DIV_STEP && !status.div_last) |=> step == STEP_DIV_STEP)
    else $error("division left before its last bit");
  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_EMIT && !status.out_free) |=> step == STEP_EMIT)
    else $error("result dropped while output busy");
`endif

endmodule

[hw/rtl/ptd_datapath.sv]
// ----------------------------------------------------------------------------
// ptd_datapath
// Candidate and divisor registers, squaring multiplier, bit-serial
// restoring remainder unit and the output register.
// ----------------------------------------------------------------------------
module ptd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  ptd_pkg::ctrl_t                     ctrl,
  output ptd_pkg::status_t                   status,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ptd_pkg::DATA_WIDTH-1:0] candidate,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               is_prime
);
  import ptd_pkg::*;

  logic [DATA_WIDTH-1:0]   value;
  logic [DATA_WIDTH-1:0]   divisor;
  logic [2*DATA_WIDTH-1:0] square;
  logic [DATA_WIDTH-1:0]   rem;
  logic [DATA_WIDTH-1:0]   shift;
  logic [CNT_W-1:0]        cnt;
  logic                    verdict;
  logic [DATA_WIDTH:0]     trial;
  logic [DATA_WIDTH:0]     diff;
  logic                    out_free;

  assign trial    = {rem, shift[DATA_WIDTH-1]};
  assign diff     = trial - {1'b0, divisor};
  assign out_free = !out_valid || out_ready;
  assign in_ready = (ctrl.op == OP_LOAD);

  always_comb begin
    status.start    = in_valid;
    status.trivial  = value[DATA_WIDTH-1] || (value <= DATA_WIDTH'(1));
    status.sq_gt    = square > {{DATA_WIDTH{1'b0}}, value};
    status.div_last = (cnt == CNT_W'(DATA_WIDTH - 1));
    status.rem_zero = (rem == '0);
    status.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        value   <= candidate;
        divisor <= DATA_WIDTH'(2);
      end
      OP_SQUARE: begin
        square <= divisor * divisor;
      end
      OP_DIV_INIT: begin
        rem   <= '0;
        shift <= value;
        cnt   <= '0;
      end
      OP_DIV_STEP: begin
        shift <= {shift[DATA_WIDTH-2:0], 1'b0};
        cnt   <= cnt + CNT_W'(1);
        if (diff[DATA_WIDTH]) begin
          rem <= trial[DATA_WIDTH-1:0];
        end else begin
          rem <= diff[DATA_WIDTH-1:0];
        end
      end
      OP_INC: begin
        divisor <= divisor + DATA_WIDTH'(1);
      end
      OP_SET_PASS: begin
        verdict <= 1'b1;
      end
      OP_SET_FAIL: begin
        verdict <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && out_free) begin
      is_prime <= verdict;
    end
  end

`ifndef SYNTHESIS
  a_divisor_min: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_SQUARE) |-> divisor >= DATA_WIDTH'(2))
    else $error("divisor below two");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT && out_free) |=> out_valid)
    else $error("result not presented");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV_STEP) |=> rem < divisor)
    else $error("partial remainder not below divisor");
`endif

endmodule

[hw/rtl/primality_trial_division.sv]
// A negative candidate or one below two is failed without any trial division; otherwise
// each trial divisor goes through square, compare, remainder init, one step per remainder
// bit, check and increment. Worst case is a prime near 2^31: about 46340 trials. One
// request is worked on at a time; the next is taken the cycle after the result is
// registered. Reset is synchronous and clears the step counter and the output valid flag.
// ----------------------------------------------------------------------------
// primality_trial_division
// Microcoded trial division primality tester for signed 32-bit requests.
// ----------------------------------------------------------------------------
module primality_trial_division (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ptd_pkg::DATA_WIDTH-1:0] candidate,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  is_prime
);
  import ptd_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  ptd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  ptd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_prime  (is_prime)
  );

endmodule
